/* src/pfdrc_pkg.sv */
// Shared types and constants for the packet FIFO with duplicate check and range count.
`timescale 1ns / 1ps

package pfdrc_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int LIMIT_W   = 7;
  localparam int COUNT_W   = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_FORWARD = 2'd1,
    OP_COUNT   = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
  } pkt_t;

  localparam int PKT_W = $bits(pkt_t);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] source;
    logic [15:0] destination;
    logic [31:0] timestamp;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } in_item_t;

  typedef struct packed {
    logic               added;
    logic               forward_valid;
    logic [15:0]        out_source;
    logic [15:0]        out_destination;
    logic [31:0]        out_timestamp;
    logic [COUNT_W-1:0] match_count;
  } out_item_t;

endpackage

/* src/pfdrc_in_if.sv */
// Request channel interface: valid, ready and one request word.
`timescale 1ns / 1ps

interface pfdrc_in_if;
  logic                valid;
  logic                ready;
  pfdrc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/pfdrc_out_if.sv */
// Result channel interface: valid, ready and one result word.
`timescale 1ns / 1ps

interface pfdrc_out_if;
  logic                 valid;
  logic                 ready;
  pfdrc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/packet_fifo_dedup_range_count_core.sv */
// Top level: bounded packet FIFO with duplicate rejection and destination/time range count.
`timescale 1ns / 1ps

// Requests arrive on in_ch (valid/ready) as one word holding an opcode and
// packet fields: add stores a packet unless an identical one is held,
// evicting the oldest when the occupancy limit is reached; forward pops the
// oldest packet; count returns how many held packets match a destination
// within an inclusive time window. One result word per request leaves on
// out_ch from an output register.
// Add and count walk every held entry through the packet RAM, one read per
// cycle into a single shared compare unit; forward reads only the oldest
// entry, and the unused opcode and any request on an empty FIFO read none.
// A new request is taken only once the current one has finished. The RAM
// read port sets the pace.
// in_ch.ready is high only while no request is in progress. A request may be
// accepted while the previous result still waits on out_ch; it holds at its
// final step until that result is taken, so nothing is lost under stall.
// cfg_we writes the occupancy limit (0 acts as 1, above DEPTH acts as DEPTH).
// Synchronous reset empties the FIFO and sets the limit to 64; RAM contents
// are not cleared since only occupied entries are ever read.
module packet_fifo_dedup_range_count_core #(
  parameter int DEPTH = pfdrc_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pfdrc_in_if.sink                         in_ch,
  pfdrc_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [pfdrc_pkg::LIMIT_W-1:0]    cfg_wdata
);

  localparam int PKT_W_LOCAL = pfdrc_pkg::PKT_W;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > pfdrc_pkg::LIMIT_W) ? OCC_W : pfdrc_pkg::LIMIT_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  state_t                          state_r, state_nxt;
  logic [pfdrc_pkg::LIMIT_W-1:0]   limit_r;
  logic [PTR_W-1:0]                head_r, head_nxt;
  logic [PTR_W-1:0]                tail_r, tail_nxt;
  logic [OCC_W-1:0]                occ_r, occ_nxt;
  logic [OCC_W-1:0]                scan_len_r, scan_len_nxt;
  logic [OCC_W-1:0]                issue_cnt_r, issue_cnt_nxt;
  logic [PTR_W-1:0]                scan_ptr_r, scan_ptr_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic                            dup_r, dup_nxt;
  logic [pfdrc_pkg::COUNT_W-1:0]   cnt_r, cnt_nxt;
  pfdrc_pkg::in_item_t             req_r;
  logic                            out_valid_r, out_valid_nxt;
  pfdrc_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                            in_fire;
  logic                            rd_issue;
  logic                            out_free;
  logic                            done;
  logic                            ram_we;
  logic [PKT_W_LOCAL-1:0]          ram_rdata;
  pfdrc_pkg::pkt_t                 ent;
  pfdrc_pkg::pkt_t                 new_pkt;
  logic                            hit_dup;
  logic                            hit_cnt;
  logic [CMP_W-1:0]                lim_raw;
  logic [CMP_W-1:0]                eff_lim;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign rd_issue = (issue_cnt_r != scan_len_r);
  assign done     = (state_r == ST_SCAN) && !rd_issue && !rd_pend_r && out_free;

  assign ent = pfdrc_pkg::pkt_t'(ram_rdata);
  assign new_pkt = '{src: req_r.source, dst: req_r.destination, ts: req_r.timestamp};

  // shared compare unit, fed by one RAM read per cycle
  assign hit_dup = (ent.src == req_r.source) && (ent.dst == req_r.destination) &&
                   (ent.ts == req_r.timestamp);
  assign hit_cnt = (ent.dst == req_r.destination) && (ent.ts >= req_r.start_time) &&
                   (ent.ts <= req_r.end_time);

  always_comb begin
    lim_raw = CMP_W'(limit_r);
    eff_lim = lim_raw;
    if (lim_raw == '0) begin
      eff_lim = CMP_W'(1);
    end else if (lim_raw > CMP_W'(DEPTH)) begin
      eff_lim = CMP_W'(DEPTH);
    end
  end

  assign ram_we = done && (req_r.opcode == pfdrc_pkg::OP_ADD) && !dup_r;

  pfdrc_ram #(
    .WIDTH (PKT_W_LOCAL),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (new_pkt),
    .re    ((state_r == ST_SCAN) && rd_issue),
    .raddr (scan_ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    scan_len_nxt  = scan_len_r;
    issue_cnt_nxt = issue_cnt_r;
    scan_ptr_nxt  = scan_ptr_r;
    rd_pend_nxt   = 1'b0;
    dup_nxt       = dup_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt     = ST_SCAN;
          issue_cnt_nxt = '0;
          scan_ptr_nxt  = head_r;
          dup_nxt       = 1'b0;
          cnt_nxt       = '0;
          case (in_ch.data.opcode) inside
            pfdrc_pkg::OP_ADD, pfdrc_pkg::OP_COUNT: scan_len_nxt = occ_r;
            pfdrc_pkg::OP_FORWARD: scan_len_nxt = (occ_r != '0) ? OCC_W'(1) : '0;
            default: scan_len_nxt = '0;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_issue) begin
          issue_cnt_nxt = issue_cnt_r + OCC_W'(1);
          scan_ptr_nxt  = wrap_inc(scan_ptr_r);
          rd_pend_nxt   = 1'b1;
        end
        if (rd_pend_r) begin
          if (hit_dup) begin
            dup_nxt = 1'b1;
          end
          if (hit_cnt) begin
            cnt_nxt = cnt_r + pfdrc_pkg::COUNT_W'(1);
          end
        end
        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          case (req_r.opcode)
            pfdrc_pkg::OP_ADD: begin
              if (!dup_r) begin
                out_data_nxt.added = 1'b1;
                tail_nxt = wrap_inc(tail_r);
                // at the limit: drop the oldest, occupancy holds
                if (CMP_W'(occ_r) >= eff_lim) begin
                  head_nxt = wrap_inc(head_r);
                end else begin
                  occ_nxt = occ_r + OCC_W'(1);
                end
              end
            end
            pfdrc_pkg::OP_FORWARD: begin
              if (scan_len_r != '0) begin
                out_data_nxt.forward_valid   = 1'b1;
                out_data_nxt.out_source      = ent.src;
                out_data_nxt.out_destination = ent.dst;
                out_data_nxt.out_timestamp   = ent.ts;
                head_nxt = wrap_inc(head_r);
                occ_nxt  = occ_r - OCC_W'(1);
              end
            end
            pfdrc_pkg::OP_COUNT: begin
              out_data_nxt.match_count = cnt_r;
            end
            default: begin
              out_data_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= pfdrc_pkg::LIMIT_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      scan_len_r  <= '0;
      issue_cnt_r <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      scan_len_r  <= scan_len_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_ch.data;
    end
    scan_ptr_r <= scan_ptr_nxt;
    dup_r      <= dup_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

/* src/pfdrc_ram.sv */
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module pfdrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
